@@ src/tklt_pkg.sv @@
package tklt_pkg;
    localparam int MaxPointsDefault = 64;
    localparam int MaxTopDefault    = 8;
    localparam int CoordBitsDefault = 16;
    localparam int TopCountReset    = 8;
    localparam logic OpAdd = 1'b0;
    localparam logic OpRun = 1'b1;
endpackage

@@ src/tklt_ram.sv @@
module tklt_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/top_k_largest_triangles.sv @@
// Channel | Direction | Payload
// in      | input     | op, point_x, point_y
// cfg     | input     | top_count (4 bits)
// out     | output    | rank, double_area, vertices, points_dropped, last
// An add writes the point to the point RAM; once the RAM is full it sets points_dropped.
// A run steps through each triple (three reads, multiply, cross, insertion
// into the top list, advance), then emits one result beat per kept rank.
// Synchronous active-low reset clears control state and the top-list areas.
// Output beats hold while i_out_ready is low; no input is taken during a run.
module top_k_largest_triangles
    import tklt_pkg::*;
#(
    parameter int MAX_POINTS = MaxPointsDefault,
    parameter int MAX_TOP    = MaxTopDefault,
    parameter int COORD_BITS = CoordBitsDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_op,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [3:0]                   i_top_count,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_rank,
    output logic [2*COORD_BITS:0]        o_double_area,
    output logic signed [COORD_BITS-1:0] o_vertex_a_x,
    output logic signed [COORD_BITS-1:0] o_vertex_a_y,
    output logic signed [COORD_BITS-1:0] o_vertex_b_x,
    output logic signed [COORD_BITS-1:0] o_vertex_b_y,
    output logic signed [COORD_BITS-1:0] o_vertex_c_x,
    output logic signed [COORD_BITS-1:0] o_vertex_c_y,
    output logic                         o_points_dropped,
    output logic                         o_last
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int TW = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
    localparam int KW = $clog2(MAX_TOP + 1);
    localparam int PW = 2 * COORD_BITS;
    localparam int DW = 2 * COORD_BITS + 1;
    localparam int DIFW = COORD_BITS + 1;
    localparam int PRW = 2 * DIFW;
    localparam int CRW = PRW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RDA, S_RDB, S_RDC, S_MUL, S_CROSS, S_INS, S_NEXT, S_EMIT
    } t_state;

    typedef logic signed [COORD_BITS-1:0] t_crd;

    t_state r_state;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [3:0]    r_topc;
    logic [KW-1:0] r_k;
    logic [AW-1:0] r_i, r_j, r_l;
    t_crd r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [PRW-1:0] r_p1, r_p2;
    logic [DW-1:0]  r_area;
    logic [TW-1:0]  r_pos;
    logic [DW-1:0]  r_top_area [MAX_TOP];
    logic [3*PW-1:0] r_top_vtx [MAX_TOP];
    logic [TW-1:0]  r_slot;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [PW-1:0] ram_rdata;
    logic          in_acc;
    logic signed [CRW-1:0] cross_val;
    logic [KW-1:0] k_eff;

    assign o_in_ready  = (r_state == S_IDLE) && !o_out_valid;
    assign o_cfg_ready = (r_state == S_IDLE) && !o_out_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign ram_we      = in_acc && (i_op == OpAdd) && (r_count < CW'(MAX_POINTS));

    always_comb begin
        ram_raddr = r_i;
        case (r_state)
            S_RDA:   ram_raddr = r_i;
            S_RDB:   ram_raddr = r_j;
            S_RDC:   ram_raddr = r_l;
            default: ram_raddr = r_i;
        endcase
    end

    tklt_ram #(.Width(PW), .Depth(MAX_POINTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata({i_point_x, i_point_y}),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        if (r_topc == 4'd0) begin
            k_eff = KW'(1);
        end else if (32'(r_topc) > MAX_TOP) begin
            k_eff = KW'(MAX_TOP);
        end else begin
            k_eff = KW'(r_topc);
        end
    end

    assign cross_val = CRW'(r_p1) - CRW'(r_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_topc      <= 4'(TopCountReset);
            o_out_valid <= 1'b0;
            for (int m = 0; m < MAX_TOP; m++) begin
                r_top_area[m] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_topc <= i_top_count;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_op == OpAdd) begin
                            if (r_count < CW'(MAX_POINTS)) begin
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end else begin
                            r_k <= k_eff;
                            for (int m = 0; m < MAX_TOP; m++) begin
                                r_top_area[m] <= '0;
                            end
                            r_i <= '0;
                            r_j <= AW'(1);
                            r_l <= AW'(2);
                            r_slot <= '0;
                            r_state <= (r_count >= CW'(3)) ? S_RDA : S_EMIT;
                        end
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    r_ax <= t_crd'(ram_rdata[PW-1:COORD_BITS]);
                    r_ay <= t_crd'(ram_rdata[COORD_BITS-1:0]);
                    r_state <= S_RDC;
                end
                S_RDC: begin
                    r_bx <= t_crd'(ram_rdata[PW-1:COORD_BITS]);
                    r_by <= t_crd'(ram_rdata[COORD_BITS-1:0]);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_cx <= t_crd'(ram_rdata[PW-1:COORD_BITS]);
                    r_cy <= t_crd'(ram_rdata[COORD_BITS-1:0]);
                    r_p1 <= (DIFW'(r_bx) - DIFW'(r_ax))
                          * (DIFW'(t_crd'(ram_rdata[COORD_BITS-1:0])) - DIFW'(r_ay));
                    r_p2 <= (DIFW'(t_crd'(ram_rdata[PW-1:COORD_BITS])) - DIFW'(r_ax))
                          * (DIFW'(r_by) - DIFW'(r_ay));
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    r_area  <= DW'(cross_val < 0 ? -cross_val : cross_val);
                    r_pos   <= '0;
                    r_state <= S_INS;
                end
                S_INS: begin
                    if (KW'(r_pos) >= r_k) begin
                        r_state <= S_NEXT;
                    end else if (r_area <= r_top_area[r_pos]) begin
                        if (KW'(r_pos) + 1'b1 >= r_k) begin
                            r_state <= S_NEXT;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end else begin
                        for (int m = MAX_TOP - 1; m > 0; m--) begin
                            if (m > r_pos) begin
                                r_top_area[m] <= r_top_area[m-1];
                                r_top_vtx[m]  <= r_top_vtx[m-1];
                            end
                        end
                        r_top_area[r_pos] <= r_area;
                        r_top_vtx[r_pos]  <= {r_ax, r_ay, r_bx, r_by, r_cx, r_cy};
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_state <= S_RDA;
                    if (CW'(r_l) + 1'b1 < r_count) begin
                        r_l <= r_l + 1'b1;
                    end else if (CW'(r_j) + 2'd2 < r_count) begin
                        r_j <= r_j + 1'b1;
                        r_l <= r_j + AW'(2);
                    end else if (CW'(r_i) + 2'd3 < r_count) begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_i + AW'(2);
                        r_l <= r_i + AW'(3);
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid      <= 1'b1;
                        o_rank           <= 3'(r_slot);
                        o_double_area    <= r_top_area[r_slot];
                        {o_vertex_a_x, o_vertex_a_y, o_vertex_b_x, o_vertex_b_y,
                         o_vertex_c_x, o_vertex_c_y} <=
                            (r_top_area[r_slot] != '0) ? r_top_vtx[r_slot] : '0;
                        o_points_dropped <= r_ovf;
                        o_last           <= (KW'(r_slot) + 1'b1 == r_k);
                        if (KW'(r_slot) + 1'b1 == r_k) begin
                            r_state <= S_IDLE;
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                        end else begin
                            r_slot <= r_slot + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_out_valid && i_out_ready && r_state != S_EMIT) begin
                o_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("input taken while busy");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS)) else $error("point count overflow");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && MAX_TOP > 1) |-> r_top_area[0] >= r_top_area[MAX_TOP-1])
        else $error("list not descending");
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && $past(r_state) == S_EMIT && $past(o_out_valid)
         && $past(o_last) && $past(i_out_ready)) |-> 1'b0)
        else $error("emit after last");
`endif
endmodule

@@ verif/top_k_largest_triangles_test.sv @@
module top_k_largest_triangles_test;
    import tklt_pkg::*;

    localparam int NumPoints     = MaxPointsDefault;
    localparam int NumTop        = MaxTopDefault;
    localparam int CoordBits     = CoordBitsDefault;
    localparam int StallLimit    = 3000000;
    localparam int SettleCycles  = 16;

    typedef logic signed [CoordBits-1:0] t_coord;

    typedef struct {
        logic [2:0]          rank;
        logic [2*CoordBits:0] area;
        t_coord              ax, ay, bx, by, cx, cy;
        logic                dropped;
        logic                last;
    } t_tri_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_op = OpAdd;
    t_coord                i_point_x = '0;
    t_coord                i_point_y = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [3:0]            i_top_count = 4'd0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [2:0]            o_rank;
    logic [2*CoordBits:0]  o_double_area;
    t_coord                o_vertex_a_x, o_vertex_a_y;
    t_coord                o_vertex_b_x, o_vertex_b_y;
    t_coord                o_vertex_c_x, o_vertex_c_y;
    logic                  o_points_dropped;
    logic                  o_last;

    top_k_largest_triangles uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_top_count     (i_top_count),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_rank          (o_rank),
        .o_double_area   (o_double_area),
        .o_vertex_a_x    (o_vertex_a_x),
        .o_vertex_a_y    (o_vertex_a_y),
        .o_vertex_b_x    (o_vertex_b_x),
        .o_vertex_b_y    (o_vertex_b_y),
        .o_vertex_c_x    (o_vertex_c_x),
        .o_vertex_c_y    (o_vertex_c_y),
        .o_points_dropped(o_points_dropped),
        .o_last          (o_last)
    );

    t_coord    stored_x[NumPoints];
    t_coord    stored_y[NumPoints];
    int        stored_count = 0;
    bit        overflowed = 1'b0;
    logic [3:0] kept_count = 4'(TopCountReset);
    t_tri_beat ranked_q[$];

    int        send_idle = 0;
    int        recv_stall = 0;
    int        errors = 0;
    int        quiet_cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic void rank_triangles();
        longint    best[NumTop];
        int        vi[NumTop], vj[NumTop], vl[NumTop];
        int        k, pos;
        longint    cr, ar;
        t_tri_beat b;
        k = kept_count;
        if (k < 1) k = 1;
        if (k > NumTop) k = NumTop;
        for (int s = 0; s < NumTop; s++) begin
            best[s] = 0; vi[s] = 0; vj[s] = 0; vl[s] = 0;
        end
        for (int i = 0; i < stored_count; i++)
            for (int j = i + 1; j < stored_count; j++)
                for (int l = j + 1; l < stored_count; l++) begin
                    cr = (longint'(stored_x[j]) - longint'(stored_x[i]))
                       * (longint'(stored_y[l]) - longint'(stored_y[i]))
                       - (longint'(stored_x[l]) - longint'(stored_x[i]))
                       * (longint'(stored_y[j]) - longint'(stored_y[i]));
                    ar = (cr < 0) ? -cr : cr;
                    pos = 0;
                    while (pos < k && ar <= best[pos]) pos++;
                    if (pos < k) begin
                        for (int m = k - 1; m > pos; m--) begin
                            best[m] = best[m-1];
                            vi[m] = vi[m-1]; vj[m] = vj[m-1]; vl[m] = vl[m-1];
                        end
                        best[pos] = ar; vi[pos] = i; vj[pos] = j; vl[pos] = l;
                    end
                end
        for (int s = 0; s < k; s++) begin
            b.rank = s[2:0];
            b.area = best[s][2*CoordBits:0];
            if (best[s] != 0) begin
                b.ax = stored_x[vi[s]]; b.ay = stored_y[vi[s]];
                b.bx = stored_x[vj[s]]; b.by = stored_y[vj[s]];
                b.cx = stored_x[vl[s]]; b.cy = stored_y[vl[s]];
            end else begin
                b.ax = '0; b.ay = '0; b.bx = '0; b.by = '0; b.cx = '0; b.cy = '0;
            end
            b.dropped = overflowed;
            b.last = (s + 1 == k);
            ranked_q.push_back(b);
        end
        stored_count = 0;
        overflowed = 1'b0;
    endfunction

    // Leaves valid high after the beat unless it inserts idle cycles; callers that wait must lower it first.
    task automatic send_item(logic op, t_coord x, t_coord y);
        i_in_valid <= 1'b1;
        i_op <= op;
        i_point_x <= x;
        i_point_y <= y;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OpAdd) begin
            if (stored_count < NumPoints) begin
                stored_x[stored_count] = x;
                stored_y[stored_count] = y;
                stored_count++;
            end else begin
                overflowed = 1'b1;
            end
        end else begin
            rank_triangles();
        end
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (ranked_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_top_count(logic [3:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_top_count <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        kept_count = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_coord pick_coord(int mode);
        case (mode)
            0: pick_coord = t_coord'($urandom);
            1: pick_coord = t_coord'($urandom_range(6) - 3);
            default: begin
                case ($urandom_range(3))
                    0: pick_coord = t_coord'(-32768);
                    1: pick_coord = t_coord'(32767);
                    2: pick_coord = t_coord'(0);
                    default: pick_coord = t_coord'(-1);
                endcase
            end
        endcase
    endfunction

    task automatic load_and_search(int n, int mode);
        for (int p = 0; p < n; p++) send_item(OpAdd, pick_coord(mode), pick_coord(mode));
        send_item(OpRun, t_coord'($urandom), t_coord'($urandom));
    endtask

    task automatic test_short_sets();
        send_item(OpRun, '0, '0);
        send_item(OpAdd, 16'sd5, -16'sd7);
        send_item(OpRun, '0, '0);
        send_item(OpAdd, 16'sd1, 16'sd1);
        send_item(OpAdd, 16'sd2, 16'sd2);
        send_item(OpRun, '0, '0);
    endtask

    task automatic test_extremes();
        // collinear triple: no entry
        send_item(OpAdd, 16'sd0, 16'sd0);
        send_item(OpAdd, 16'sd3, 16'sd3);
        send_item(OpAdd, -16'sd4, -16'sd4);
        send_item(OpRun, -16'sd1, 16'sd1);
        send_item(OpAdd, -16'sd32768, -16'sd32768);
        send_item(OpAdd, 16'sd32767, -16'sd32768);
        send_item(OpAdd, 16'sd32767, 16'sd32767);
        send_item(OpAdd, -16'sd32768, 16'sd32767);
        send_item(OpAdd, -16'sd32768, -16'sd32768);
        send_item(OpRun, 16'sd32767, -16'sd32768);
        // a square gives four equal areas: earlier triangles win the ties
        send_item(OpAdd, 16'sd0, 16'sd0);
        send_item(OpAdd, 16'sd2, 16'sd0);
        send_item(OpAdd, 16'sd2, 16'sd2);
        send_item(OpAdd, 16'sd0, 16'sd2);
        send_item(OpAdd, 16'sd1, 16'sd1);
        send_item(OpRun, '0, '0);
    endtask

    task automatic test_top_count();
        logic [3:0] values[7] = '{4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd9, 4'd15};
        foreach (values[v]) begin
            write_top_count(values[v]);
            load_and_search(6, 1);
        end
        write_top_count(4'd8);
    endtask

    task automatic test_overflow();
        for (int p = 0; p < NumPoints + 2; p++)
            send_item(OpAdd, pick_coord(p % 3), pick_coord(0));
        send_item(OpRun, '0, '0);
        load_and_search(4, 0);
    endtask

    task automatic test_random(int idle_pct, int stall_pct);
        int n;
        send_idle = idle_pct;
        recv_stall = stall_pct;
        for (int set = 0; set < 6; set++) begin
            if ($urandom_range(2) == 0) write_top_count(4'($urandom_range(15)));
            n = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(9, 3);
            load_and_search(n, $urandom_range(2));
            if (set == 2) drain();
        end
        drain();
        send_idle = 0;
        recv_stall = 0;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        t_tri_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (ranked_q.size() == 0) begin
                report_mismatch("unexpected beat rank", o_rank, 0);
            end else begin
                want = ranked_q.pop_front();
                if (o_rank !== want.rank) report_mismatch("rank", o_rank, want.rank);
                if (o_double_area !== want.area)
                    report_mismatch("double_area", o_double_area, want.area);
                if (o_vertex_a_x !== want.ax) report_mismatch("vertex_a_x", o_vertex_a_x, want.ax);
                if (o_vertex_a_y !== want.ay) report_mismatch("vertex_a_y", o_vertex_a_y, want.ay);
                if (o_vertex_b_x !== want.bx) report_mismatch("vertex_b_x", o_vertex_b_x, want.bx);
                if (o_vertex_b_y !== want.by) report_mismatch("vertex_b_y", o_vertex_b_y, want.by);
                if (o_vertex_c_x !== want.cx) report_mismatch("vertex_c_x", o_vertex_c_x, want.cx);
                if (o_vertex_c_y !== want.cy) report_mismatch("vertex_c_y", o_vertex_c_y, want.cy);
                if (o_points_dropped !== want.dropped)
                    report_mismatch("points_dropped", o_points_dropped, want.dropped);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready)
            || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= StallLimit) begin
            $display("top_k_largest_triangles_test NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_sets();
        test_extremes();
        test_top_count();
        test_overflow();
        test_random(0, 0);
        test_random(64, 0);
        test_random(0, 64);
        test_random(7, 7);
        write_top_count(4'd3);
        load_and_search(8, 0);
        drain();
        if (errors == 0) begin
            $display("top_k_largest_triangles_test OK");
        end else begin
            $display("top_k_largest_triangles_test NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/tklt_pkg.sv
src/tklt_ram.sv
src/top_k_largest_triangles.sv
verif/top_k_largest_triangles_test.sv
